[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the delta timer queue datapath. They expand to
// nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define DTQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define DTQ_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define DTQ_ASSERT(label, clk, rst, prop, msg)
`define DTQ_NEVER(label, clk, rst, cond, msg)
`endif

`endif

[sv/dtq_pkg.sv]
// ---------------------------------------------------------------------------
// dtq_pkg
// Types, field widths and codes shared by the delta timer queue modules.
// ---------------------------------------------------------------------------
package dtq_pkg;

   // default sizing
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TIME_BITS_DEF   = 16;

   // field widths
   localparam int OP_W       = 2;
   localparam int DELAY_W    = 16;
   localparam int ID_W       = 8;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_POP    = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   // commands from the controller to the datapath
   typedef struct packed {
      logic                load_req;    // capture request, clear pointer
      logic                scan_rd;     // read entry at pointer
      logic                walk_adv;    // insert walk: rest -= delta, pointer++
      logic                scan_adv;    // remove scan: pointer++
      logic                set_pos;     // pos = pointer, keep read entry
      logic                shup_rd;     // read entry below pointer
      logic                shup_wr;     // write it at pointer, pointer--
      logic                place;       // write new entry at pos, count++
      logic                shdn_rd;     // read entry above pointer
      logic                shdn_wr;     // write it at pointer, pointer++
      logic                shdn_end;    // count--
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
      logic                load_rsp;    // move result into output register
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            empty;
      logic            full;
      logic            ptr_lt_count;
      logic            walk_le;      // read delta <= remaining delay
      logic            id_match;
      logic            shup_more;    // pointer > pos
      logic            shdn_more;    // pointer + 1 < count
   } stat_type;

endpackage

[sv/dtq_datapath.sv]
// ---------------------------------------------------------------------------
// dtq_datapath
// Entry memories, entry count, walk pointer and result registers of the
// delta timer queue. Acts on commands from dtq_ctrl.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dtq_datapath
   import dtq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  cmd_type               cmd,
   output stat_type              stat,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // request fields
   logic [OP_W-1:0]    req_op;
   logic [DELAY_W-1:0] req_delay;
   logic [ID_W-1:0]    req_id;
   logic [TIME_BITS-1:0] delay_sat;

   assign req_op    = req_tdata[OP_W-1:0];
   assign req_delay = req_tdata[OP_W+DELAY_W-1:OP_W];
   assign req_id    = req_tdata[OP_W+DELAY_W+ID_W-1:OP_W+DELAY_W];

   // clamp the delay to the time width
   if (TIME_BITS >= DELAY_W) begin : g_wide_time
      assign delay_sat = TIME_BITS'(req_delay);
   end else begin : g_narrow_time
      assign delay_sat = ((req_delay >> TIME_BITS) != '0) ? '1 : req_delay[TIME_BITS-1:0];
   end

   // working registers
   logic [OP_W-1:0]      op_ff, op_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [TIME_BITS-1:0] rest_ff, rest_in;
   logic [TIME_BITS-1:0] saved_ff, saved_in;
   logic [CW-1:0]        ptr_ff, ptr_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [ID_W-1:0]      popped_ff, popped_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [RSP_DATA_W-1:0] rsp_ff, rsp_in;

   // memory read data
   logic [TIME_BITS-1:0] rd_delta_ff;
   logic [ID_W-1:0]      rd_thread_ff;

   logic [CW-1:0] ptr_inc;
   logic [CW-1:0] ptr_dec;
   logic [CW-1:0] pos_inc;

   assign ptr_inc = ptr_ff + CW'(1);
   assign ptr_dec = ptr_ff - CW'(1);
   assign pos_inc = pos_ff + CW'(1);

   // register next values
   always_comb begin
      op_in     = op_ff;
      id_in     = id_ff;
      rest_in   = rest_ff;
      saved_in  = saved_ff;
      ptr_in    = ptr_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      popped_in = popped_ff;
      status_in = status_ff;
      rsp_in    = rsp_ff;

      if (cmd.load_req) begin
         op_in     = req_op;
         id_in     = req_id;
         rest_in   = delay_sat;
         ptr_in    = '0;
         popped_in = '0;
         status_in = ST_OK;
      end
      if (cmd.walk_adv) begin
         rest_in = rest_ff - rd_delta_ff;
         ptr_in  = ptr_inc;
      end
      if (cmd.scan_adv) begin
         ptr_in = ptr_inc;
      end
      if (cmd.set_pos) begin
         pos_in   = ptr_ff;
         saved_in = rd_delta_ff;
         if (op_ff == OP_POP) begin
            popped_in = rd_thread_ff;
         end
         if (op_ff == OP_INSERT) begin
            ptr_in = count_ff;
         end
      end
      if (cmd.shup_wr) begin
         ptr_in = ptr_dec;
      end
      if (cmd.place) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.shdn_wr) begin
         ptr_in = ptr_inc;
      end
      if (cmd.shdn_end) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.set_status) begin
         status_in = cmd.status_code;
      end
      if (cmd.load_rsp) begin
         rsp_in = RSP_DATA_W'({status_ff, popped_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      op_ff     <= op_in;
      id_ff     <= id_in;
      rest_ff   <= rest_in;
      saved_ff  <= saved_in;
      ptr_ff    <= ptr_in;
      pos_ff    <= pos_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   // entry memories, one read and one write port each
   logic [TIME_BITS-1:0] delta_mem  [QUEUE_DEPTH];
   logic [ID_W-1:0]      thread_mem [QUEUE_DEPTH];

   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [TIME_BITS-1:0] wr_delta;
   logic [ID_W-1:0]      wr_thread;

   // read address select
   always_comb begin
      rd_en   = cmd.scan_rd | cmd.shup_rd | cmd.shdn_rd;
      rd_addr = ptr_ff[AW-1:0];
      if (cmd.shup_rd) begin
         rd_addr = ptr_dec[AW-1:0];
      end else if (cmd.shdn_rd) begin
         rd_addr = ptr_inc[AW-1:0];
      end
   end

   // write select; the entry next to pos takes the delta fix
   always_comb begin
      wr_en     = cmd.shup_wr | cmd.shdn_wr | cmd.place;
      wr_addr   = ptr_ff[AW-1:0];
      wr_delta  = rd_delta_ff;
      wr_thread = rd_thread_ff;
      if (cmd.place) begin
         wr_addr   = pos_ff[AW-1:0];
         wr_delta  = rest_ff;
         wr_thread = id_ff;
      end else if (cmd.shup_wr && (ptr_ff == pos_inc)) begin
         wr_delta = rd_delta_ff - rest_ff;
      end else if (cmd.shdn_wr && (ptr_ff == pos_ff)) begin
         wr_delta = rd_delta_ff + saved_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         delta_mem[wr_addr]  <= wr_delta;
         thread_mem[wr_addr] <= wr_thread;
      end
      if (rd_en) begin
         rd_delta_ff  <= delta_mem[rd_addr];
         rd_thread_ff <= thread_mem[rd_addr];
      end
   end

   // status to the controller
   always_comb begin
      stat.op           = op_ff;
      stat.empty        = (count_ff == '0);
      stat.full         = (count_ff == CW'(QUEUE_DEPTH));
      stat.ptr_lt_count = (ptr_ff < count_ff);
      stat.walk_le      = (rd_delta_ff <= rest_ff);
      stat.id_match     = (rd_thread_ff == id_ff);
      stat.shup_more    = (ptr_ff > pos_ff);
      stat.shdn_more    = (ptr_inc < count_ff);
   end

   assign rsp_tdata = rsp_ff;

   `DTQ_NEVER(a_count_range, clock, reset, count_ff > CW'(QUEUE_DEPTH), "entry count over depth")
   `DTQ_ASSERT(a_place_not_full, clock, reset, cmd.place |-> !stat.full, "insert into full queue")
   `DTQ_ASSERT(a_drop_not_empty, clock, reset, cmd.shdn_end |-> !stat.empty, "drop from empty queue")
   `DTQ_ASSERT(a_shdn_in_range, clock, reset, cmd.shdn_wr |-> ptr_inc < count_ff, "shift past tail")

endmodule

[sv/dtq_ctrl.sv]
// ---------------------------------------------------------------------------
// dtq_ctrl
// Sequencer of the delta timer queue: walks, shifts and places entries one
// memory access per cycle, and owns both handshakes.
// ---------------------------------------------------------------------------
module dtq_ctrl
   import dtq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_SCAN_RD = 4'd2;
   localparam logic [3:0] S_SCAN_CK = 4'd3;
   localparam logic [3:0] S_SHUP_RD = 4'd4;
   localparam logic [3:0] S_SHUP_WR = 4'd5;
   localparam logic [3:0] S_SHDN_RD = 4'd6;
   localparam logic [3:0] S_SHDN_WR = 4'd7;
   localparam logic [3:0] S_FINISH  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op)
               OP_INSERT: begin
                  if (stat.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_FULL;
                     state_in        = S_FINISH;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
               OP_POP, OP_REMOVE: begin
                  if (stat.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_EMPTY;
                     state_in        = S_FINISH;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SCAN_RD: begin
            if (stat.ptr_lt_count) begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN_CK;
            end else if (stat.op == OP_INSERT) begin
               // new entry goes at the tail
               cmd.set_pos = 1'b1;
               state_in    = S_SHUP_RD;
            end else begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_NOT_FOUND;
               state_in        = S_FINISH;
            end
         end
         S_SCAN_CK: begin
            if (stat.op == OP_INSERT) begin
               if (stat.walk_le) begin
                  cmd.walk_adv = 1'b1;
                  state_in     = S_SCAN_RD;
               end else begin
                  cmd.set_pos = 1'b1;
                  state_in    = S_SHUP_RD;
               end
            end else if ((stat.op == OP_POP) || stat.id_match) begin
               cmd.set_pos = 1'b1;
               state_in    = S_SHDN_RD;
            end else begin
               cmd.scan_adv = 1'b1;
               state_in     = S_SCAN_RD;
            end
         end
         // open a slot at pos, tail first
         S_SHUP_RD: begin
            if (stat.shup_more) begin
               cmd.shup_rd = 1'b1;
               state_in    = S_SHUP_WR;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_FINISH;
            end
         end
         S_SHUP_WR: begin
            cmd.shup_wr = 1'b1;
            state_in    = S_SHUP_RD;
         end
         // close the gap at pos, head first
         S_SHDN_RD: begin
            if (stat.shdn_more) begin
               cmd.shdn_rd = 1'b1;
               state_in    = S_SHDN_WR;
            end else begin
               cmd.shdn_end = 1'b1;
               state_in     = S_FINISH;
            end
         end
         S_SHDN_WR: begin
            cmd.shdn_wr = 1'b1;
            state_in    = S_SHDN_RD;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[sv/delta_timer_queue.sv]
// Operation: insert walks from the head past every entry due no later than it, then shifts
// the later entries up and places it; pop and remove scan for their entry, then shift down.
// Rejected requests (full, empty) and unused codes go straight to the result.
// One request at a time: the next one is accepted in the cycle after the result loads; each
// entry walked is read then checked, each one shifted read then written; result stalls hold it.
// Reset: synchronous, active high; clears entry count and handshakes, not the entry store.
// ---------------------------------------------------------------------------
// delta_timer_queue
// Bounded queue of sleeping threads in wake-up order, each entry holding its
// delay relative to the one before it. Supports insert, pop head, remove by id.
// ---------------------------------------------------------------------------
module delta_timer_queue
   import dtq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // operation[1:0], delay[17:2], thread_id[25:18]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // popped_id[7:0], status[9:8]
);

   cmd_type  cmd;
   stat_type stat;

   dtq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dtq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TIME_BITS   (TIME_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

endmodule
